@@ src/mac_receive_address_table_macros.svh @@
// -----------------------------------------------------------------------------
// mac_receive_address_table_macros
// Assertion macros used by the receive address table RTL (mrat_back).
// -----------------------------------------------------------------------------
`ifndef MAC_RECEIVE_ADDRESS_TABLE_MACROS_SVH
`define MAC_RECEIVE_ADDRESS_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define MRAT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expr must never be true outside reset
`define MRAT_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `MRAT_ASSERT(lbl, clk, rstn, !(expr), msg)

`else

`define MRAT_ASSERT(lbl, clk, rstn, prop, msg)
`define MRAT_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

@@ src/mrat_pkg.sv @@
// -----------------------------------------------------------------------------
// mrat_pkg
// Types and constants of the receive MAC address table.
// -----------------------------------------------------------------------------
package mrat_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W        = 48;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int SLOT_W        = 4;

    // request queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_PRIMARY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        OP_PRIMARY,
        OP_ADD,
        OP_REMOVE,
        OP_NOP
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_queue_head;

endpackage

@@ src/mrat_front.sv @@
// -----------------------------------------------------------------------------
// mrat_front
// Takes requests, decodes the mode and queues them for the table walker.
// -----------------------------------------------------------------------------
module mrat_front
    import mrat_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [ADDR_W-1:0]   i_mac_addr,
    input  logic                i_pop,
    output t_queue_head         o_head
);

    t_req              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_push;
    t_req              w_req;

    always_comb begin
        case (i_mode)
            MODE_PRIMARY: w_req.op = OP_PRIMARY;
            MODE_ADD:     w_req.op = OP_ADD;
            MODE_REMOVE:  w_req.op = OP_REMOVE;
            default:      w_req.op = OP_NOP;
        endcase
        w_req.addr = i_mac_addr;
    end

    assign o_busy = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign w_push = i_start && !o_busy;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.req   = r_q[r_rp];

    always_comb begin
        n_wp  = w_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + QCNT_W'(w_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end

endmodule

@@ src/mrat_back.sv @@
// -----------------------------------------------------------------------------
// mrat_back
// Executes queued requests: walks the address store one entry per cycle.
// -----------------------------------------------------------------------------
`include "mac_receive_address_table_macros.svh"

module mrat_back
    import mrat_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_queue_head         i_head,
    output logic                o_pop,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [ADDR_W-1:0]        r_mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0]        r_rdata;
    logic [TABLE_ENTRIES-1:0] r_valid;

    t_state             r_state, n_state;
    t_op                r_op;
    logic [ADDR_W-1:0]  r_key;
    logic [IDX_W-1:0]   r_idx;
    logic               r_issue;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [IDX_W-1:0]   r_free;
    logic               r_free_ok;

    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;

    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [ADDR_W-1:0]   w_wdata;
    logic                w_set_valid;
    logic                w_clr_valid;
    logic [IDX_W-1:0]    w_vidx;
    logic                w_done;
    logic [STATUS_W-1:0] w_status;
    logic [IDX_W-1:0]    w_slot;
    logic                w_start_scan;
    logic                w_finish;

    logic [ADDR_W-1:0]   w_eff;
    logic                w_hit;
    logic                w_last;
    logic                w_free_here;

    // an invalid entry may hold stale data (reset or removal), so mask it on valid
    assign w_eff       = r_valid[r_cmp_idx] ? r_rdata : '0;
    assign w_hit       = r_cmp_vld && (w_eff == r_key);
    assign w_last      = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign w_free_here = r_cmp_vld && (r_cmp_idx != '0) && !r_valid[r_cmp_idx];
    assign w_finish    = (r_state == S_SCAN) && (w_hit || w_last);
    assign w_start_scan = (r_state == S_IDLE) && i_head.valid
                          && ((i_head.req.op == OP_ADD) || (i_head.req.op == OP_REMOVE));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start_scan) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_hit || w_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = r_key;
        w_set_valid = 1'b0;
        w_clr_valid = 1'b0;
        w_vidx      = '0;
        w_done      = 1'b0;
        w_status    = ST_OK;
        w_slot      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.req.op)
                        OP_PRIMARY: begin
                            w_we        = 1'b1;
                            w_wdata     = i_head.req.addr;
                            w_set_valid = 1'b1;
                            w_done      = 1'b1;
                        end
                        OP_NOP: begin
                            w_done = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    w_done = 1'b1;
                    if (r_op == OP_ADD) begin
                        w_status = ST_EXISTS;
                    end else begin
                        w_clr_valid = 1'b1;
                        w_vidx      = r_cmp_idx;
                        w_slot      = r_cmp_idx;
                    end
                end else if (w_last) begin
                    w_done = 1'b1;
                    if (r_op == OP_ADD) begin
                        if (r_free_ok || w_free_here) begin
                            w_we        = 1'b1;
                            w_waddr     = r_free_ok ? r_free : r_cmp_idx;
                            w_set_valid = 1'b1;
                            w_vidx      = w_waddr;
                            w_slot      = w_waddr;
                        end else begin
                            w_status = ST_FULL;
                        end
                    end else begin
                        w_status = ST_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_free_ok <= 1'b0;
            r_valid   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_done;
            if (w_set_valid) r_valid[w_vidx] <= 1'b1;
            if (w_clr_valid) r_valid[w_vidx] <= 1'b0;
            if (w_start_scan) begin
                r_issue   <= 1'b1;
                r_cmp_vld <= 1'b0;
                r_free_ok <= 1'b0;
            end else if (w_finish) begin
                r_issue   <= 1'b0;
                r_cmp_vld <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_cmp_vld <= r_issue;
                if (r_issue && (r_idx == LAST_IDX)) r_issue <= 1'b0;
                if (w_free_here && !r_free_ok) r_free_ok <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_status <= w_status;
        r_slot   <= SLOT_W'(w_slot);
        if (w_start_scan) begin
            r_op  <= i_head.req.op;
            r_key <= i_head.req.addr;
            r_idx <= (i_head.req.op == OP_ADD) ? '0 : IDX_W'(1);
        end else if (r_state == S_SCAN) begin
            r_cmp_idx <= r_idx;
            if (r_issue && (r_idx != LAST_IDX)) r_idx <= r_idx + 1'b1;
            if (w_free_here && !r_free_ok) r_free <= r_cmp_idx;
        end
    end

    // address store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[r_idx];
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_slot   = r_slot;

    `MRAT_ASSERT(a_pop_in_idle, i_clk, i_rst_n, o_pop |-> r_state == S_IDLE, "pop in scan")
    `MRAT_ASSERT(a_cmp_in_scan, i_clk, i_rst_n, r_cmp_vld |-> r_state == S_SCAN, "stray compare")
    `MRAT_ASSERT(a_fail_slot, i_clk, i_rst_n, r_done && r_status != ST_OK |-> r_slot == '0, "bad slot")
    `MRAT_ASSERT(a_scan_ends, i_clk, i_rst_n, w_finish |=> r_state == S_IDLE && r_done, "no result")

endmodule

@@ src/mac_receive_address_table.sv @@
// -----------------------------------------------------------------------------
// mac_receive_address_table
// Receive MAC address table: set primary, add and remove secondary addresses.
// -----------------------------------------------------------------------------
// A request is taken on start while busy is low; up to two requests wait in a
// queue ahead of the table walker, and busy is high only while that queue is
// full. Each request gives exactly one result, shown for one cycle with o_done,
// and the receiver cannot stall it. Into an idle block, set primary and the
// unused mode go through the queue and give a registered result. Add and
// remove walk the 16-entry address store one entry per cycle through its single
// registered read port, add from entry 0 and remove from entry 1: a match ends
// the walk at that entry, and without a match the walk runs to the last entry.
// A request that waits in the queue also waits for those ahead of it. The store
// needs no clearing pass after reset.
module mac_receive_address_table
    import mrat_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [ADDR_W-1:0]   i_mac_addr,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot
);

    t_queue_head w_head;
    logic        w_pop;

    mrat_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_mode     (i_mode),
        .i_mac_addr (i_mac_addr),
        .i_pop      (w_pop),
        .o_head     (w_head)
    );

    mrat_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_done   (o_done),
        .o_status (o_status),
        .o_slot   (o_slot)
    );

endmodule
